// ===== src/abscx_pkg.sv =====
// ----------------------------------------------------------------------------
// abscx_pkg
// Shared types, constants and helper functions for the branch, exchange,
// software interrupt and leading-zero execute unit.
// ----------------------------------------------------------------------------
package abscx_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDEF = 2'd1,
    ST_SWI   = 2'd2,
    ST_HALT  = 2'd3
  } status_t;

  // register branch selector codes (instruction bits 5:4)
  typedef enum logic [1:0] {
    SEL_NONE = 2'd0,
    SEL_BX   = 2'd1,
    SEL_BXJ  = 2'd2,
    SEL_BLX  = 2'd3
  } rb_sel_t;

  // decode patterns
  localparam logic [2:0]  BRANCH_IMM_OP = 3'h5;
  localparam logic [21:0] BRANCH_REG_OP = 22'h04BFFC;
  localparam logic [3:0]  SWI_OP        = 4'hF;
  localparam logic [7:0]  CLZ_OP_HI     = 8'h16;
  localparam logic [3:0]  CLZ_OP_LO     = 4'h1;
  localparam logic [3:0]  COND_NV       = 4'hF;
  localparam logic [3:0]  REG_PC        = 4'hF;
  localparam logic [23:0] HALT_CODE     = 24'h123456;

  // status register layout
  localparam int unsigned T_POS   = 5;
  localparam int unsigned I_POS   = 7;
  localparam logic [4:0]  MODE_SVC = 5'b10011;
  localparam logic [31:0] SWI_VECTOR = 32'h0000_0008;
  localparam logic [31:0] LINK_OFFSET = 32'd4;

  // one result word
  typedef struct packed {
    status_t     status;
    logic        write_pc;
    logic [31:0] new_pc;
    logic        write_link;
    logic [31:0] link_value;
    logic        write_status;
    logic [31:0] new_status;
    logic        write_saved;
    logic [31:0] saved_status;
    logic        write_dest;
    logic [3:0]  dest_index;
    logic [5:0]  dest_value;
  } result_t;

  // leading-zero count as a five-step binary search, 32 for zero
  function automatic logic [5:0] clz32(input logic [31:0] v);
    logic [31:0] x;
    logic [4:0]  n;
    x = v;
    n = '0;
    if (x[31:16] == 16'd0) begin
      n[4] = 1'b1;
      x = {x[15:0], 16'd0};
    end
    if (x[31:24] == 8'd0) begin
      n[3] = 1'b1;
      x = {x[23:0], 8'd0};
    end
    if (x[31:28] == 4'd0) begin
      n[2] = 1'b1;
      x = {x[27:0], 4'd0};
    end
    if (x[31:30] == 2'd0) begin
      n[1] = 1'b1;
      x = {x[29:0], 2'd0};
    end
    if (!x[31]) begin
      n[0] = 1'b1;
    end
    return (v == 32'd0) ? 6'd32 : {1'b0, n};
  endfunction

endpackage

// ===== src/abscx_in_if.sv =====
// ----------------------------------------------------------------------------
// abscx_in_if
// Instruction channel: one instruction word with its operands per word.
// ----------------------------------------------------------------------------
interface abscx_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;
  logic [31:0] pc_read;
  logic [31:0] rm_data;
  logic [31:0] status_word;

  modport source (output valid, output instruction, output pc_read,
                  output rm_data, output status_word, input ready);
  modport sink   (input valid, input instruction, input pc_read,
                  input rm_data, input status_word, output ready);
endinterface

// ===== src/abscx_out_if.sv =====
// ----------------------------------------------------------------------------
// abscx_out_if
// Result channel: architectural writes requested by one instruction.
// ----------------------------------------------------------------------------
interface abscx_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        write_pc;
  logic [31:0] new_pc;
  logic        write_link;
  logic [31:0] link_value;
  logic        write_status;
  logic [31:0] new_status;
  logic        write_saved;
  logic [31:0] saved_status;
  logic        write_dest;
  logic [3:0]  dest_index;
  logic [5:0]  dest_value;

  modport source (output valid, output status, output write_pc, output new_pc,
                  output write_link, output link_value, output write_status,
                  output new_status, output write_saved, output saved_status,
                  output write_dest, output dest_index, output dest_value,
                  input ready);
  modport sink   (input valid, input status, input write_pc, input new_pc,
                  input write_link, input link_value, input write_status,
                  input new_status, input write_saved, input saved_status,
                  input write_dest, input dest_index, input dest_value,
                  output ready);
endinterface

// ===== src/abscx_decode.sv =====
// ----------------------------------------------------------------------------
// abscx_decode
// Combinational decode and execute of one instruction: branch targets,
// link, status updates and leading-zero count.
// ----------------------------------------------------------------------------
module abscx_decode (
  input  logic [31:0]        instruction,
  input  logic [31:0]        pc_read,
  input  logic [31:0]        rm_data,
  input  logic [31:0]        status_word,
  output abscx_pkg::result_t res
);

  logic [3:0]  cond;
  logic        is_nv;
  logic        h_bit;
  logic [31:0] imm_offset;
  logic [31:0] imm_target;
  logic [31:0] link;
  logic [31:0] status_t_set;
  logic [31:0] status_t_clr;
  logic [31:0] status_svc;
  logic [3:0]  rd;
  logic [3:0]  rm_idx;
  abscx_pkg::rb_sel_t sel;

  assign cond   = instruction[31:28];
  assign is_nv  = (cond == abscx_pkg::COND_NV);
  assign h_bit  = instruction[24];
  assign rd     = instruction[15:12];
  assign rm_idx = instruction[3:0];
  assign sel    = abscx_pkg::rb_sel_t'(instruction[5:4]);

  // immediate target; the half-word bit fills offset bit 1 for blx
  assign imm_offset = {{6{instruction[23]}}, instruction[23:0], h_bit & is_nv, 1'b0};
  assign imm_target = pc_read + imm_offset;
  assign link       = pc_read - abscx_pkg::LINK_OFFSET;

  // status variants
  always_comb begin
    status_t_set = status_word;
    status_t_set[abscx_pkg::T_POS] = 1'b1;
    status_t_clr = status_word;
    status_t_clr[abscx_pkg::T_POS] = 1'b0;
    status_svc = status_word;
    status_svc[4:0] = abscx_pkg::MODE_SVC;
    status_svc[abscx_pkg::T_POS] = 1'b0;
    status_svc[abscx_pkg::I_POS] = 1'b1;
  end

  // instruction class select
  always_comb begin
    res = '0;
    res.status = abscx_pkg::ST_UNDEF;
    if (instruction[27:25] == abscx_pkg::BRANCH_IMM_OP) begin
      res.status   = abscx_pkg::ST_OK;
      res.write_pc = 1'b1;
      res.new_pc   = imm_target;
      if (is_nv || h_bit) begin
        res.write_link = 1'b1;
        res.link_value = link;
      end
      if (is_nv) begin
        res.write_status = 1'b1;
        res.new_status   = status_t_set;
      end
    end else if (instruction[27:6] == abscx_pkg::BRANCH_REG_OP) begin
      if (sel != abscx_pkg::SEL_NONE) begin
        res.status       = abscx_pkg::ST_OK;
        res.write_pc     = 1'b1;
        res.new_pc       = {rm_data[31:1], 1'b0};
        res.write_status = 1'b1;
        res.new_status   = rm_data[0] ? status_t_set : status_t_clr;
        if (sel == abscx_pkg::SEL_BLX) begin
          res.write_link = 1'b1;
          res.link_value = link;
        end
      end
    end else if (instruction[27:24] == abscx_pkg::SWI_OP) begin
      if (instruction[23:0] == abscx_pkg::HALT_CODE) begin
        res.status = abscx_pkg::ST_HALT;
      end else begin
        res.status       = abscx_pkg::ST_SWI;
        res.write_pc     = 1'b1;
        res.new_pc       = abscx_pkg::SWI_VECTOR;
        res.write_link   = 1'b1;
        res.link_value   = link;
        res.write_status = 1'b1;
        res.new_status   = status_svc;
        res.write_saved  = 1'b1;
        res.saved_status = status_word;
      end
    end else if (instruction[27:20] == abscx_pkg::CLZ_OP_HI &&
                 instruction[7:4] == abscx_pkg::CLZ_OP_LO) begin
      if (rd != abscx_pkg::REG_PC && rm_idx != abscx_pkg::REG_PC) begin
        res.status     = abscx_pkg::ST_OK;
        res.write_dest = 1'b1;
        res.dest_index = rd;
        res.dest_value = abscx_pkg::clz32(rm_data);
      end
    end
  end

endmodule

// ===== src/arm_branch_swi_clz_execute.sv =====
// ----------------------------------------------------------------------------
// arm_branch_swi_clz_execute
// Execute unit for immediate and register branches, software interrupt and
// count leading zeros; one result word for every instruction word.
// ----------------------------------------------------------------------------
//  port    | dir  | word contents
//  --------+------+--------------------------------------------------------
//  item    | in   | instruction, pc_read, rm_data, status_word
//  result  | out  | status and the pc, link, cpsr, spsr and rd writes
//
//  one word per cycle while result is not stalled; each word passes from the
//  input register to the result register, with the decode and leading-zero search between them.
//  rst clears both stage valid flags; no word is in flight after reset.
//  a stalled result holds in its register while the input stage still fills;
//  item.ready drops only when both stages hold words and result is stalled.
// ----------------------------------------------------------------------------
module arm_branch_swi_clz_execute (
  input logic          clk,
  input logic          rst,
  abscx_in_if.sink     item,
  abscx_out_if.source  result
);

  logic        in_valid;
  logic [31:0] in_instruction;
  logic [31:0] in_pc_read;
  logic [31:0] in_rm_data;
  logic [31:0] in_status_word;
  logic        out_valid;
  abscx_pkg::result_t out_res;
  abscx_pkg::result_t res;
  logic        load_out;
  logic        advance;

  // stage handshake
  assign load_out   = !out_valid || result.ready;
  assign advance    = in_valid && load_out;
  assign item.ready = !in_valid || load_out;

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (item.ready) begin
        in_valid <= item.valid;
      end
      if (load_out) begin
        out_valid <= in_valid;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_instruction <= item.instruction;
      in_pc_read     <= item.pc_read;
      in_rm_data     <= item.rm_data;
      in_status_word <= item.status_word;
    end
  end

  abscx_decode u_decode (
    .instruction (in_instruction),
    .pc_read     (in_pc_read),
    .rm_data     (in_rm_data),
    .status_word (in_status_word),
    .res         (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  // result port
  assign result.valid        = out_valid;
  assign result.status       = out_res.status;
  assign result.write_pc     = out_res.write_pc;
  assign result.new_pc       = out_res.new_pc;
  assign result.write_link   = out_res.write_link;
  assign result.link_value   = out_res.link_value;
  assign result.write_status = out_res.write_status;
  assign result.new_status   = out_res.new_status;
  assign result.write_saved  = out_res.write_saved;
  assign result.saved_status = out_res.saved_status;
  assign result.write_dest   = out_res.write_dest;
  assign result.dest_index   = out_res.dest_index;
  assign result.dest_value   = out_res.dest_value;

  // undefined and halt words request no writes
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_res.status == abscx_pkg::ST_UNDEF ||
                  out_res.status == abscx_pkg::ST_HALT) |->
      !(out_res.write_pc || out_res.write_link || out_res.write_status ||
        out_res.write_saved || out_res.write_dest))
    else $error("write requested on undefined or halt word");

  // only a software interrupt saves the status register
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.write_saved |-> out_res.status == abscx_pkg::ST_SWI)
    else $error("spsr write outside software interrupt");

  // leading-zero results never move the pc
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.write_dest |->
      !out_res.write_pc && out_res.dest_value <= 6'd32)
    else $error("bad leading-zero result");

  // a word in the input stage moves on when the result side is free
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_valid |=> out_valid)
    else $error("input stage did not advance");

  // a stalled result stays put
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.ready |=> out_valid && $stable(out_res))
    else $error("stalled result changed");

endmodule

// ===== dv/tb_arm_branch_swi_clz_execute.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arm_branch_swi_clz_execute
// Self-checking bench for the branch / exchange / SWI / CLZ execute unit.
// A directed table covers field extremes, every instruction class and the
// undefined and halt corner cases. Random instruction words follow, mostly
// well-formed encodings with random operands. Every accepted word is
// predicted and compared field by field against the result stream, under
// bursty input traffic and a patterned output stall.
// ----------------------------------------------------------------------------
module tb_arm_branch_swi_clz_execute;

  localparam int unsigned RANDOM_WORDS = 1750;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_REPORTS  = 10;

  // one row of the directed table; fixed rows carry a typed-in status and
  // expect every write flag and value field to be zero
  typedef struct {
    logic [31:0]         ins;
    logic [31:0]         pc;
    logic [31:0]         rm;
    logic [31:0]         cpsr;
    bit                  fixed;
    abscx_pkg::status_t  fixed_status;
  } stim_row_t;

  logic clk;
  logic rst;

  abscx_in_if  item_bus ();
  abscx_out_if result_bus ();

  arm_branch_swi_clz_execute DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus)
  );

  stim_row_t           directed_rows[$];
  abscx_pkg::result_t  expected_words[$];
  int unsigned         mismatch_count;
  int unsigned         cycle_count;
  int unsigned         burst_left;
  bit                  drv_fixed;
  abscx_pkg::status_t  drv_fixed_status;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // leading zeros of a 32-bit word, 32 when it is zero
  function automatic logic [5:0] count_lead_zeros(input logic [31:0] v);
    logic [5:0] zeros;
    zeros = 6'd32;
    for (int b = 0; b < 32; b++) begin
      if (v[b]) zeros = 6'(31 - b);
    end
    return zeros;
  endfunction

  // architectural writes caused by one instruction word
  function automatic abscx_pkg::result_t predict_execute(
    input logic [31:0] ins, input logic [31:0] pc,
    input logic [31:0] rm, input logic [31:0] cpsr);
    abscx_pkg::result_t r;
    logic [31:0] link;
    logic [31:0] offset;
    r = '0;
    r.status = abscx_pkg::ST_UNDEF;
    link = pc - abscx_pkg::LINK_OFFSET;
    if (ins[27:25] == abscx_pkg::BRANCH_IMM_OP) begin
      // immediate branch, word offset; NV condition is blx with halfword bit
      offset = {{6{ins[23]}}, ins[23:0], 2'b00};
      r.status = abscx_pkg::ST_OK;
      r.write_pc = 1'b1;
      r.new_pc = pc + offset;
      if (ins[31:28] == abscx_pkg::COND_NV || ins[24]) begin
        r.write_link = 1'b1;
        r.link_value = link;
      end
      if (ins[31:28] == abscx_pkg::COND_NV) begin
        r.new_pc = r.new_pc + {30'd0, ins[24], 1'b0};
        r.write_status = 1'b1;
        r.new_status = cpsr;
        r.new_status[abscx_pkg::T_POS] = 1'b1;
      end
    end else if (ins[27:6] == abscx_pkg::BRANCH_REG_OP) begin
      // register branch, thumb bit from rm bit 0
      if (abscx_pkg::rb_sel_t'(ins[5:4]) != abscx_pkg::SEL_NONE) begin
        r.status = abscx_pkg::ST_OK;
        r.write_pc = 1'b1;
        r.new_pc = {rm[31:1], 1'b0};
        r.write_status = 1'b1;
        r.new_status = cpsr;
        r.new_status[abscx_pkg::T_POS] = rm[0];
        if (abscx_pkg::rb_sel_t'(ins[5:4]) == abscx_pkg::SEL_BLX) begin
          r.write_link = 1'b1;
          r.link_value = link;
        end
      end
    end else if (ins[27:24] == abscx_pkg::SWI_OP) begin
      // software interrupt, or halt request on the magic comment field
      if (ins[23:0] == abscx_pkg::HALT_CODE) begin
        r.status = abscx_pkg::ST_HALT;
      end else begin
        r.status = abscx_pkg::ST_SWI;
        r.write_pc = 1'b1;
        r.new_pc = abscx_pkg::SWI_VECTOR;
        r.write_link = 1'b1;
        r.link_value = link;
        r.write_status = 1'b1;
        r.new_status = cpsr;
        r.new_status[4:0] = abscx_pkg::MODE_SVC;
        r.new_status[abscx_pkg::T_POS] = 1'b0;
        r.new_status[abscx_pkg::I_POS] = 1'b1;
        r.write_saved = 1'b1;
        r.saved_status = cpsr;
      end
    end else if (ins[27:20] == abscx_pkg::CLZ_OP_HI && ins[7:4] == abscx_pkg::CLZ_OP_LO) begin
      // count leading zeros, pc as rd or rm is undefined
      if (ins[15:12] != abscx_pkg::REG_PC && ins[3:0] != abscx_pkg::REG_PC) begin
        r.status = abscx_pkg::ST_OK;
        r.write_dest = 1'b1;
        r.dest_index = ins[15:12];
        r.dest_value = count_lead_zeros(rm);
      end
    end
    return r;
  endfunction

  task automatic add_row(input logic [31:0] ins, input logic [31:0] pc, input logic [31:0] rm,
                         input logic [31:0] cpsr, input bit fixed,
                         input abscx_pkg::status_t fixed_status);
    stim_row_t row;
    row.ins = ins;
    row.pc = pc;
    row.rm = rm;
    row.cpsr = cpsr;
    row.fixed = fixed;
    row.fixed_status = fixed_status;
    directed_rows.push_back(row);
  endtask

  // present one word, with a gap between bursts, and hold it until taken
  task automatic send_word(input logic [31:0] ins, input logic [31:0] pc, input logic [31:0] rm,
                           input logic [31:0] cpsr, input bit fixed,
                           input abscx_pkg::status_t fixed_status);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
    end else begin
      burst_left--;
    end
    if (gap != 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_bus.valid <= 1'b1;
    item_bus.instruction <= ins;
    item_bus.pc_read <= pc;
    item_bus.rm_data <= rm;
    item_bus.status_word <= cpsr;
    drv_fixed = fixed;
    drv_fixed_status = fixed_status;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // random operand with a spread of leading-zero counts
  function automatic logic [31:0] random_operand();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // random instruction word, mostly well-formed encodings of each class
  function automatic logic [31:0] random_instruction();
    logic [31:0] ins;
    int unsigned kind;
    ins = $urandom;
    kind = $urandom_range(0, 99);
    if (kind < 22) begin
      ins[27:25] = abscx_pkg::BRANCH_IMM_OP;
      if ($urandom_range(0, 2) == 0) ins[31:28] = abscx_pkg::COND_NV;
    end else if (kind < 42) begin
      ins[27:6] = abscx_pkg::BRANCH_REG_OP;
    end else if (kind < 57) begin
      ins[27:24] = abscx_pkg::SWI_OP;
      if ($urandom_range(0, 7) == 0) ins[23:0] = abscx_pkg::HALT_CODE;
    end else if (kind < 80) begin
      ins[27:20] = abscx_pkg::CLZ_OP_HI;
      ins[7:4] = abscx_pkg::CLZ_OP_LO;
    end else if (kind < 90) begin
      // near miss of the register branch pattern
      ins[27:6] = abscx_pkg::BRANCH_REG_OP;
      ins[$urandom_range(6, 27)] ^= 1'b1;
    end
    return ins;
  endfunction

  // receiver: ready pattern whose character switches among random modes
  initial begin
    int unsigned mode;
    int unsigned tick;
    logic [31:0] pattern;
    result_bus.ready = 1'b0;
    mode = 0;
    tick = 0;
    pattern = '1;
    forever begin
      @(negedge clk);
      if (tick % 50 == 0) begin
        mode = $urandom_range(0, 3);
        pattern = $urandom | 32'h1;
      end
      case (mode)
        0:       result_bus.ready <= 1'b1;
        1:       result_bus.ready <= ($urandom_range(0, 9) < 7);
        2:       result_bus.ready <= ($urandom_range(0, 9) < 3);
        default: result_bus.ready <= pattern[tick % 32];
      endcase
      tick++;
    end
  end

  // predict every accepted instruction word
  always @(posedge clk) begin
    abscx_pkg::result_t exp_word;
    if (!rst && item_bus.valid && item_bus.ready) begin
      if (drv_fixed) begin
        exp_word = '0;
        exp_word.status = drv_fixed_status;
      end else begin
        exp_word = predict_execute(item_bus.instruction, item_bus.pc_read,
                                   item_bus.rm_data, item_bus.status_word);
      end
      expected_words.push_back(exp_word);
    end
  end

  task automatic note_field(input string name, input logic [31:0] exp_v,
                            input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("mismatch on %s at cycle %0d: expected %h, got %h",
                 name, cycle_count, exp_v, act_v);
    end
  endtask

  // compare each result word with the oldest prediction
  always @(posedge clk) begin
    abscx_pkg::result_t exp_word;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (expected_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result word at cycle %0d", cycle_count);
      end else begin
        exp_word = expected_words.pop_front();
        note_field("status", exp_word.status, result_bus.status);
        note_field("write_pc", exp_word.write_pc, result_bus.write_pc);
        note_field("new_pc", exp_word.new_pc, result_bus.new_pc);
        note_field("write_link", exp_word.write_link, result_bus.write_link);
        note_field("link_value", exp_word.link_value, result_bus.link_value);
        note_field("write_status", exp_word.write_status, result_bus.write_status);
        note_field("new_status", exp_word.new_status, result_bus.new_status);
        note_field("write_saved", exp_word.write_saved, result_bus.write_saved);
        note_field("saved_status", exp_word.saved_status, result_bus.saved_status);
        note_field("write_dest", exp_word.write_dest, result_bus.write_dest);
        note_field("dest_index", exp_word.dest_index, result_bus.dest_index);
        note_field("dest_value", exp_word.dest_value, result_bus.dest_value);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL arm_branch_swi_clz_execute");
      $finish;
    end
  end

  // stimulus and verdict
  initial begin
    mismatch_count = 0;
    cycle_count = 0;
    burst_left = 0;
    drv_fixed = 1'b0;
    drv_fixed_status = abscx_pkg::ST_OK;
    item_bus.valid = 1'b0;
    item_bus.instruction = '0;
    item_bus.pc_read = '0;
    item_bus.rm_data = '0;
    item_bus.status_word = '0;
    rst = 1'b1;

    // immediate branches: zero, extreme offsets, blx with both halfword bits
    add_row(32'hEA00_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0010, 1'b0,
            abscx_pkg::ST_OK);
    add_row(32'hEA7F_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0,
            abscx_pkg::ST_OK);
    add_row(32'hEB80_0000, 32'h0000_0004, 32'h1234_5678, 32'h6000_001F, 1'b0,
            abscx_pkg::ST_OK);
    add_row(32'hEBFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0,
            abscx_pkg::ST_OK);
    add_row(32'hFA00_0010, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000, 1'b0,
            abscx_pkg::ST_OK);
    add_row(32'hFBFF_FFFF, 32'h0000_0008, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0,
            abscx_pkg::ST_OK);
    // register branches: bx, bxj, blx, and the undefined zero selector
    add_row(32'hE12F_FF1E, 32'h0000_1000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0,
            abscx_pkg::ST_OK);
    add_row(32'hE12F_FF1E, 32'hFFFF_FFFC, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0,
            abscx_pkg::ST_OK);
    add_row(32'hE12F_FF23, 32'h0000_2000, 32'h8000_0001, 32'h0000_00D3, 1'b0,
            abscx_pkg::ST_OK);
    add_row(32'hE12F_FF33, 32'h0000_0000, 32'h1234_5678, 32'h0000_0030, 1'b0,
            abscx_pkg::ST_OK);
    add_row(32'hE12F_FF03, 32'h0000_4000, 32'h0000_0001, 32'h0000_0010, 1'b1,
            abscx_pkg::ST_UNDEF);
    // software interrupt and halt request
    add_row(32'hEF00_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0,
            abscx_pkg::ST_OK);
    add_row(32'hEFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0,
            abscx_pkg::ST_OK);
    add_row(32'hEF12_3456, 32'h0000_0100, 32'h0000_0000, 32'h0000_0010, 1'b1,
            abscx_pkg::ST_HALT);
    add_row(32'hFF12_3456, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
            abscx_pkg::ST_HALT);
    // count leading zeros: zero, all ones, one, top bit, pc as rd or rm
    add_row(32'hE16F_1F12, 32'h0000_0000, 32'h0000_0000, 32'h0000_0010, 1'b0,
            abscx_pkg::ST_OK);
    add_row(32'hE16F_2F13, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0010, 1'b0,
            abscx_pkg::ST_OK);
    add_row(32'hE16F_0F10, 32'h0000_0000, 32'h0000_0001, 32'h0000_0010, 1'b0,
            abscx_pkg::ST_OK);
    add_row(32'hE16F_EF1E, 32'h0000_0000, 32'h8000_0000, 32'h0000_0010, 1'b0,
            abscx_pkg::ST_OK);
    add_row(32'hE16F_FF12, 32'h0000_0000, 32'h0000_0001, 32'h0000_0010, 1'b1,
            abscx_pkg::ST_UNDEF);
    add_row(32'hE16F_1F1F, 32'h0000_0000, 32'h0000_0001, 32'h0000_0010, 1'b1,
            abscx_pkg::ST_UNDEF);
    // unmatched words
    add_row(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1,
            abscx_pkg::ST_UNDEF);
    add_row(32'hE081_2003, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
            abscx_pkg::ST_UNDEF);

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[i])
      send_word(directed_rows[i].ins, directed_rows[i].pc, directed_rows[i].rm,
                directed_rows[i].cpsr, directed_rows[i].fixed, directed_rows[i].fixed_status);

    // random instruction words
    for (int unsigned n = 0; n < RANDOM_WORDS; n++)
      send_word(random_instruction(), $urandom, random_operand(), $urandom, 1'b0,
                abscx_pkg::ST_OK);
    item_bus.valid <= 1'b0;

    // drain
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_words.size() != 0)
      $display("%0d expected result words never arrived", expected_words.size());
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("PASS arm_branch_swi_clz_execute");
    end else begin
      $display("FAIL arm_branch_swi_clz_execute");
    end
    $finish;
  end

endmodule
